// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL. Empty bodies under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/fpnm_pkg.sv =====
package fpnm_pkg;

   localparam int unsigned NODE_COUNT_DEF  = 1024;
   localparam int unsigned GROUP_COUNT_DEF = 16;

   localparam int unsigned IDX_W     = 10;
   localparam int unsigned GROUP_W   = 4;
   localparam int unsigned SCORE_W   = 10;
   localparam int unsigned SET_OUT_W = 16;
   localparam int unsigned SET_MAX_W = 64;

   localparam logic [SCORE_W-1:0] SCORE_MAX = 10'd1023;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_COMBINE = 1'b1;

   typedef struct packed {
      logic               func;
      logic [IDX_W-1:0]   node_index;
      logic [IDX_W-1:0]   left_index;
      logic [IDX_W-1:0]   right_index;
      logic [GROUP_W-1:0] leaf_group;
      logic               leaf_unassigned;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]     written_node;
      logic [SET_OUT_W-1:0] group_set;
      logic [SCORE_W-1:0]   score;
      logic                 changed;
   } rsp_type;

endpackage

// ===== hdl/fitch_parsimony_node_merge.sv =====
// Fitch parsimony node merge: leaf load / child combine over a node memory.
// The req beat registers stage 1 and the node memory reads; the merge is
//   combinational, and the write-back and output register load happen when
//   stage 1 retires into a free output register. A new request is taken
//   only once stage 1 is empty (next item reads after the previous one wrote).
// Reset: synchronous, active high; clears control only. Node memory holds no
//   reset value; an entry must be written before it is read.
`include "assert_macros.svh"

module fitch_parsimony_node_merge #(
   parameter int unsigned NODE_COUNT  = fpnm_pkg::NODE_COUNT_DEF,
   parameter int unsigned GROUP_COUNT = fpnm_pkg::GROUP_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fpnm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fpnm_pkg::rsp_type rsp_data
);

   // Address and index widths. Indices are 10 bits on the port; the memory
   // depth may be smaller or larger, so indices are widened before slicing.
   localparam int unsigned ADDR_W  = $clog2(NODE_COUNT);
   localparam int unsigned IDXX_W  = (ADDR_W > fpnm_pkg::IDX_W) ? ADDR_W : fpnm_pkg::IDX_W;
   localparam int unsigned ENTRY_W = GROUP_COUNT + fpnm_pkg::SCORE_W;
   localparam int unsigned GCMP_W  = 7;

   // ---------------------------------------------------------------------
   // Stage 1: item held while the memory read is in flight / merge waits.
   // ---------------------------------------------------------------------
   fpnm_pkg::req_type s1_req_ff;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_lrange_ff;
   logic              s1_rrange_ff;

   // Output register (the skid between merge and the rsp channel).
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   fpnm_pkg::rsp_type rsp_data_ff;
   fpnm_pkg::rsp_type rsp_data_in;

   logic req_beat;
   logic retire;

   // Widened indices and range checks.
   logic [IDXX_W-1:0] l_idx;
   logic [IDXX_W-1:0] r_idx;
   logic [IDXX_W-1:0] n_idx;
   logic              l_range;
   logic              r_range;
   logic              n_range;

   // Memory ports. Two copies written together give two reads per cycle.
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_entry;
   logic [ENTRY_W-1:0] l_entry;
   logic [ENTRY_W-1:0] r_entry;

   // Merge datapath.
   logic [GROUP_COUNT-1:0]        l_set;
   logic [GROUP_COUNT-1:0]        r_set;
   logic [GROUP_COUNT-1:0]        both_set;
   logic [GROUP_COUNT-1:0]        new_set;
   logic [GROUP_COUNT-1:0]        leaf_set;
   logic [fpnm_pkg::SCORE_W-1:0]  l_score;
   logic [fpnm_pkg::SCORE_W-1:0]  r_score;
   logic [fpnm_pkg::SCORE_W:0]    score_sum;
   logic [fpnm_pkg::SCORE_W-1:0]  new_score;
   logic                          new_changed;
   logic [fpnm_pkg::SET_MAX_W-1:0] set_wide;

   assign req_ready = !s1_valid_ff;
   assign req_beat  = req_valid && req_ready;
   // Stage 1 retires into the output register when that register is free.
   assign retire    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);

   assign l_idx   = IDXX_W'(req_data.left_index);
   assign r_idx   = IDXX_W'(req_data.right_index);
   assign n_idx   = IDXX_W'(s1_req_ff.node_index);
   assign l_range = ({1'b0, l_idx} < (IDXX_W + 1)'(NODE_COUNT));
   assign r_range = ({1'b0, r_idx} < (IDXX_W + 1)'(NODE_COUNT));
   assign n_range = ({1'b0, n_idx} < (IDXX_W + 1)'(NODE_COUNT));

   fpnm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_COUNT)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (n_idx[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (req_beat),
      .rd_addr (l_idx[ADDR_W-1:0]),
      .rd_data (l_entry)
   );

   fpnm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_COUNT)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (n_idx[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (req_beat),
      .rd_addr (r_idx[ADDR_W-1:0]),
      .rd_data (r_entry)
   );

   // ---------------------------------------------------------------------
   // Merge: Fitch rule on the two child sets, or a leaf load.
   // ---------------------------------------------------------------------
   always_comb begin
      // out-of-range children read as empty set, score 0
      l_set   = s1_lrange_ff ? l_entry[GROUP_COUNT-1:0] : '0;
      r_set   = s1_rrange_ff ? r_entry[GROUP_COUNT-1:0] : '0;
      l_score = s1_lrange_ff ? l_entry[ENTRY_W-1:GROUP_COUNT] : '0;
      r_score = s1_rrange_ff ? r_entry[ENTRY_W-1:GROUP_COUNT] : '0;

      both_set = l_set & r_set;

      // an unassigned leaf, or a group past the configured count, loads the empty set
      if (!s1_req_ff.leaf_unassigned &&
          (GCMP_W'(s1_req_ff.leaf_group) < GCMP_W'(GROUP_COUNT))) begin
         leaf_set = GROUP_COUNT'(1) << s1_req_ff.leaf_group;
      end else begin
         leaf_set = '0;
      end

      new_changed = 1'b0;
      if (s1_req_ff.func == fpnm_pkg::FUNC_LOAD) begin
         new_set   = leaf_set;
         score_sum = '0;
      end else begin
         if ((l_set != '0) && (r_set != '0) && (both_set == '0)) begin
            new_changed = 1'b1;
         end
         if ((l_set != '0) && (r_set != '0) && (both_set != '0)) begin
            new_set = both_set;
         end else begin
            new_set = l_set | r_set;
         end
         score_sum = {1'b0, l_score} + {1'b0, r_score}
                     + {{fpnm_pkg::SCORE_W{1'b0}}, new_changed};
      end

      // saturate
      if (score_sum > {1'b0, fpnm_pkg::SCORE_MAX}) begin
         new_score = fpnm_pkg::SCORE_MAX;
      end else begin
         new_score = score_sum[fpnm_pkg::SCORE_W-1:0];
      end

      set_wide = fpnm_pkg::SET_MAX_W'(new_set);
   end

   // write dropped for an out-of-range parent, result still reported
   assign wr_en    = retire && n_range;
   assign wr_entry = {new_score, new_set};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end else if (retire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (retire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in.written_node = s1_req_ff.node_index;
      rsp_data_in.group_set    = set_wide[fpnm_pkg::SET_OUT_W-1:0];
      rsp_data_in.score        = new_score;
      rsp_data_in.changed      = new_changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_beat) begin
         s1_req_ff    <= req_data;
         s1_lrange_ff <= l_range;
         s1_rrange_ff <= r_range;
      end
      if (retire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ASSERT_NEXT(a_beat_loads_s1, clock, reset, req_beat, s1_valid_ff)
   `ASSERT_NEXT(a_retire_fills_out, clock, reset, retire, rsp_valid_ff && !s1_valid_ff)
   `ASSERT_IMPLY(a_wr_on_retire, clock, reset, wr_en, s1_valid_ff && (!rsp_valid_ff || rsp_ready))
   `ASSERT_IMPLY(a_changed_scores, clock, reset, rsp_valid_ff && rsp_data_ff.changed, rsp_data_ff.score != '0)

endmodule

// ===== hdl/fpnm_ram.sv =====
module fpnm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
